[rtl/core/mam_pkg.sv]
// Shared types and constants for the modular arithmetic accumulator.
package mam_pkg;

    localparam int MOD_W  = 31;
    localparam int OPD_W  = 32;
    localparam int PROD_W = 33;
    localparam int CNT_W  = 5;
    localparam int CMD_W  = 3;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MOD_W-1:0]  DEFAULT_MODULUS = 31'd1000000007;
    localparam logic [MOD_W-1:0]  MIN_MODULUS     = 31'd2;
    localparam logic [ADDR_W-1:0] ADDR_MODULUS    = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_INC  = 3'd5,
        CMD_DEC  = 3'd6,
        CMD_NOP  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        MOP_RED_ACC = 3'd0,
        MOP_RED_OPR = 3'd1,
        MOP_MUL     = 3'd2,
        MOP_POW_MUL = 3'd3,
        MOP_POW_SQ  = 3'd4,
        MOP_FINAL   = 3'd5
    } mul_op_t;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_RED_ACC  = 9'b000000010,
        ST_RED_OPR  = 9'b000000100,
        ST_DISPATCH = 9'b000001000,
        ST_POW_CHK  = 9'b000010000,
        ST_POW_MUL  = 9'b000100000,
        ST_POW_SQ   = 9'b001000000,
        ST_FINAL    = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    typedef struct packed {
        logic    load;
        logic    mul_start;
        mul_op_t mul_op;
        logic    pow_init;
        logic    exec;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
        logic rhs_zero;
        cmd_t cmd;
        logic out_busy;
    } dp_status_t;

endpackage

[rtl/core/mam_mulmod.sv]
// Bit-serial modular multiplier: product of x and y modulo m, one bit of y per cycle.
module mam_mulmod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mam_pkg::MOD_W-1:0]  mul_x,
    input  logic [mam_pkg::OPD_W-1:0]  mul_y,
    input  logic [mam_pkg::MOD_W-1:0]  modulus,
    output logic                       busy,
    output logic                       done,
    output logic [mam_pkg::MOD_W-1:0]  product
);
    import mam_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPD_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MOD_W-1:0]  r_reg, r_next;
    logic [MOD_W-1:0]  x_reg, x_next;
    logic [OPD_W-1:0]  y_reg, y_next;

    logic [PROD_W-1:0] t_sum;
    logic [PROD_W-1:0] m_one;
    logic [PROD_W-1:0] m_two;
    logic [PROD_W-1:0] t_sub1;
    logic [PROD_W-1:0] t_sub2;
    logic [MOD_W-1:0]  r_step;

    // r = 2r + bit*x, then bring back below m (at most two subtractions)
    always_comb
    begin
        t_sum  = {1'b0, r_reg, 1'b0} + (y_reg[OPD_W-1] ? {2'b00, x_reg} : '0);
        m_one  = {2'b00, modulus};
        m_two  = {1'b0, modulus, 1'b0};
        t_sub1 = t_sum - m_one;
        t_sub2 = t_sum - m_two;
        if (t_sum >= m_two)
        begin
            r_step = t_sub2[MOD_W-1:0];
        end
        else if (t_sum >= m_one)
        begin
            r_step = t_sub1[MOD_W-1:0];
        end
        else
        begin
            r_step = t_sum[MOD_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (busy_reg)
        begin
            r_next   = r_step;
            y_next   = {y_reg[OPD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            r_next    = '0;
            x_next    = mul_x;
            y_next    = mul_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = r_reg;

`ifndef ASSERT_OFF
    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("multiplier started while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CNT_LAST) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after last bit");

    a_product_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < modulus))
        else $error("multiplier result not reduced");
`endif

endmodule

[rtl/core/mam_dp.sv]
// Datapath: item registers, accumulator, exponent state, simple ops and result register.
module mam_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mam_pkg::MOD_W-1:0]  modulus,
    input  logic [mam_pkg::CMD_W-1:0]  in_command,
    input  logic [mam_pkg::OPD_W-1:0]  in_operand,
    input  mam_pkg::ctrl_cmd_t         ctrl,
    output mam_pkg::dp_status_t        status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mam_pkg::MOD_W-1:0]  value
);
    import mam_pkg::*;

    cmd_t             cmd_reg, cmd_next;
    mul_op_t          op_reg, op_next;
    logic [OPD_W-1:0] opd_reg, opd_next;
    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [MOD_W-1:0] a_reg, a_next;
    logic [MOD_W-1:0] rhs_reg, rhs_next;
    logic [MOD_W-1:0] base_reg, base_next;
    logic [MOD_W-1:0] res_reg, res_next;
    logic [MOD_W-1:0] exp_reg, exp_next;
    logic             out_valid_reg, out_valid_next;
    logic [MOD_W-1:0] value_reg, value_next;

    logic [MOD_W-1:0] mul_x;
    logic [OPD_W-1:0] mul_y;
    logic             mul_busy;
    logic             mul_done;
    logic [MOD_W-1:0] product;

    logic [OPD_W-1:0] add_sum;
    logic [OPD_W-1:0] add_red;
    logic [MOD_W-1:0] a_inc;
    logic [MOD_W-1:0] simple_res;

    always_comb
    begin
        unique case (ctrl.mul_op)
            MOP_RED_ACC:
            begin
                mul_x = MOD_W'(1);
                mul_y = {1'b0, acc_reg};
            end
            MOP_RED_OPR:
            begin
                mul_x = MOD_W'(1);
                mul_y = opd_reg;
            end
            MOP_MUL:
            begin
                mul_x = a_reg;
                mul_y = {1'b0, rhs_reg};
            end
            MOP_POW_MUL:
            begin
                mul_x = res_reg;
                mul_y = {1'b0, base_reg};
            end
            MOP_POW_SQ:
            begin
                mul_x = base_reg;
                mul_y = {1'b0, base_reg};
            end
            MOP_FINAL:
            begin
                mul_x = a_reg;
                mul_y = {1'b0, res_reg};
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    mam_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.mul_start),
        .mul_x   (mul_x),
        .mul_y   (mul_y),
        .modulus (modulus),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (product)
    );

    // simple commands on reduced a and rhs, computed combinationally
    always_comb
    begin
        add_sum = {1'b0, a_reg} + {1'b0, rhs_reg};
        add_red = (add_sum >= {1'b0, modulus}) ? add_sum - {1'b0, modulus} : add_sum;
        a_inc   = a_reg + 1'b1;
        unique case (cmd_reg)
            CMD_LOAD: simple_res = rhs_reg;
            CMD_ADD:  simple_res = add_red[MOD_W-1:0];
            CMD_SUB:  simple_res = (a_reg < rhs_reg) ? a_reg - rhs_reg + modulus
                                                     : a_reg - rhs_reg;
            CMD_INC:  simple_res = (a_inc == modulus) ? '0 : a_inc;
            CMD_DEC:  simple_res = (a_reg == '0) ? modulus - 1'b1 : a_reg - 1'b1;
            CMD_DIV:  simple_res = '0;
            CMD_MUL:  simple_res = a_reg;
            CMD_NOP:  simple_res = a_reg;
            default:  simple_res = a_reg;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        op_next        = op_reg;
        opd_next       = opd_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        rhs_next       = rhs_reg;
        base_next      = base_reg;
        res_next       = res_reg;
        exp_next       = exp_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;

        if (ctrl.load)
        begin
            cmd_next = cmd_t'(in_command);
            opd_next = in_operand;
        end
        if (ctrl.mul_start)
        begin
            op_next = ctrl.mul_op;
        end
        if (mul_done)
        begin
            unique case (op_reg)
                MOP_RED_ACC: a_next   = product;
                MOP_RED_OPR: rhs_next = product;
                MOP_POW_MUL: res_next = product;
                MOP_POW_SQ:
                begin
                    base_next = product;
                    exp_next  = exp_reg >> 1;
                end
                MOP_MUL:     acc_next = product;
                MOP_FINAL:   acc_next = product;
                default:     acc_next = acc_reg;
            endcase
        end
        if (ctrl.pow_init)
        begin
            res_next  = MOD_W'(1);
            base_next = rhs_reg;
            exp_next  = modulus - MOD_W'(2);
        end
        if (ctrl.exec)
        begin
            acc_next = simple_res;
        end

        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
            value_next     = acc_reg;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= MOP_RED_ACC;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        opd_reg   <= opd_next;
        a_reg     <= a_next;
        rhs_reg   <= rhs_next;
        base_reg  <= base_next;
        res_reg   <= res_next;
        exp_reg   <= exp_next;
        value_reg <= value_next;
    end

    always_comb
    begin
        status.mul_done = mul_done;
        status.exp_zero = (exp_reg == '0);
        status.exp_lsb  = exp_reg[0];
        status.rhs_zero = (rhs_reg == '0);
        status.cmd      = cmd_reg;
        status.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

`ifndef ASSERT_OFF
    a_exec_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |=> (acc_reg < modulus))
        else $error("accumulator left unreduced by single-cycle command");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mul_start |-> !mul_busy)
        else $error("multiplication issued to a busy unit");
`endif

endmodule

[rtl/core/mam_ctrl.sv]
// Controller: sequences reductions, simple ops, square-and-multiply and result hand-off.
module mam_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mam_pkg::dp_status_t  status,
    output mam_pkg::ctrl_cmd_t   ctrl
);
    import mam_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        ctrl.load      = 1'b0;
        ctrl.mul_start = 1'b0;
        ctrl.mul_op    = MOP_RED_ACC;
        ctrl.pow_init  = 1'b0;
        ctrl.exec      = 1'b0;
        ctrl.out_load  = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load      = 1'b1;
                    ctrl.mul_start = 1'b1;
                    ctrl.mul_op    = MOP_RED_ACC;
                    state_next     = ST_RED_ACC;
                end
            end
            ST_RED_ACC:
            begin
                if (status.mul_done)
                begin
                    ctrl.mul_start = 1'b1;
                    ctrl.mul_op    = MOP_RED_OPR;
                    state_next     = ST_RED_OPR;
                end
            end
            ST_RED_OPR:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (status.cmd == CMD_MUL)
                begin
                    ctrl.mul_start = 1'b1;
                    ctrl.mul_op    = MOP_MUL;
                    state_next     = ST_FINAL;
                end
                else if (status.cmd == CMD_DIV && !status.rhs_zero)
                begin
                    ctrl.pow_init = 1'b1;
                    state_next    = ST_POW_CHK;
                end
                else
                begin
                    ctrl.exec  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_POW_CHK:
            begin
                ctrl.mul_start = 1'b1;
                priority if (status.exp_zero)
                begin
                    ctrl.mul_op = MOP_FINAL;
                    state_next  = ST_FINAL;
                end
                else if (status.exp_lsb)
                begin
                    ctrl.mul_op = MOP_POW_MUL;
                    state_next  = ST_POW_MUL;
                end
                else
                begin
                    ctrl.mul_op = MOP_POW_SQ;
                    state_next  = ST_POW_SQ;
                end
            end
            ST_POW_MUL:
            begin
                if (status.mul_done)
                begin
                    ctrl.mul_start = 1'b1;
                    ctrl.mul_op    = MOP_POW_SQ;
                    state_next     = ST_POW_SQ;
                end
            end
            ST_POW_SQ:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_POW_CHK;
                end
            end
            ST_FINAL:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_pow_leaves_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POW_SQ && status.mul_done) |=> (state_reg == ST_POW_CHK))
        else $error("square step not followed by exponent check");
`endif

endmodule

[rtl/core/modular_arithmetic_accumulator_core.sv]
// Top level: stream ports, APB modulus register, controller and datapath.
// Holds one residue modulo the programmed modulus (values 0 and 1 act as 2,
// reset value 1000000007) and returns the new residue for every command beat.
// One item at a time: each beat first reduces the accumulator and the operand
// through a bit-serial modular multiplier; load, add, sub, increment and
// decrement are then computed directly from the reduced values, and multiply
// takes one more product. Divide raises the operand to the power modulus-2 by
// square-and-multiply on the same multiplier, at most 62 further products: a
// square for each bit and a multiply for each set bit of modulus-2, then the
// final product. The next beat is taken while the previous result still waits
// in the output register.
module modular_arithmetic_accumulator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [31:0] operand
    input  logic [7:0]                   s_tuser,   // [2:0] command, rest zero
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [30:0] value, [31] zero
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mam_pkg::ADDR_W-1:0]   paddr,
    input  logic [mam_pkg::DATA_W-1:0]   pwdata,
    output logic [mam_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import mam_pkg::*;

    logic [MOD_W-1:0] modulus_reg, modulus_next;
    logic [MOD_W-1:0] mod_eff;
    logic             cfg_wr;
    logic [MOD_W-1:0] value;
    ctrl_cmd_t        ctrl;
    dp_status_t       status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MODULUS);

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_wr)
        begin
            modulus_next = pwdata[MOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= DEFAULT_MODULUS;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    assign prdata  = (paddr == ADDR_MODULUS) ? {1'b0, modulus_reg} : '0;
    assign mod_eff = (modulus_reg < MIN_MODULUS) ? MIN_MODULUS : modulus_reg;

    mam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    mam_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .modulus    (mod_eff),
        .in_command (s_tuser[CMD_W-1:0]),
        .in_operand (s_tdata),
        .ctrl       (ctrl),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .value      (value)
    );

    assign m_tdata = {1'b0, value};

endmodule

[bench/testbench.sv]
// Self-checking testbench for the modular arithmetic accumulator core.
module testbench;
    import mam_pkg::*;

    localparam int LIMIT       = 10_000_000;
    localparam int TAIL        = 8;
    localparam int HOLD_CYCLES = 2000;
    localparam int RANDOM_BEATS = 900;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [31:0]       s_tdata  = '0;
    logic [7:0]        s_tuser  = '0;
    logic              m_tready = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic              s_tready;
    logic              m_tvalid;
    logic [31:0]       m_tdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [MOD_W-1:0]  acc_shadow     = '0;
    logic [MOD_W-1:0]  modulus_shadow = DEFAULT_MODULUS;
    logic [MOD_W-1:0]  residue_q[$];
    int                fail_count     = 0;
    longint            cycle_count    = 0;
    int                sent_count     = 0;
    bit                quiet          = 1'b0;
    bit                hold_request   = 1'b0;

    modular_arithmetic_accumulator_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint unsigned effective_modulus();
        return (modulus_shadow < 2) ? 64'd2 : 64'(modulus_shadow);
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                                longint unsigned m);
        longint unsigned r;
        r = 1 % m;
        while (e != 0)
        begin
            if (e[0])
                r = (r * base) % m;
            base = (base * base) % m;
            e = e >> 1;
        end
        return r;
    endfunction

    // New accumulator residue after one command; updates the shadow copy.
    function automatic logic [MOD_W-1:0] apply_command(cmd_t c, logic [31:0] opd);
        longint unsigned m;
        longint unsigned rhs;
        longint unsigned a;
        m   = effective_modulus();
        rhs = 64'(opd) % m;
        a   = 64'(acc_shadow) % m;
        case (c)
            CMD_LOAD: a = rhs;
            CMD_ADD:
            begin
                a = a + rhs;
                if (a >= m)
                    a = a - m;
            end
            CMD_SUB:
            begin
                if (a < rhs)
                    a = a + m;
                a = a - rhs;
            end
            CMD_MUL:  a = (a * rhs) % m;
            CMD_DIV:  a = (rhs == 0) ? 64'd0 : (a * pow_mod(rhs, m - 2, m)) % m;
            CMD_INC:
            begin
                a = a + 1;
                if (a >= m)
                    a = a - m;
            end
            CMD_DEC:
            begin
                if (a == 0)
                    a = m;
                a = a - 1;
            end
            default: ;
        endcase
        acc_shadow = a[MOD_W-1:0];
        return acc_shadow;
    endfunction

    always @(posedge clk)
    begin
        logic [MOD_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (residue_q.size() == 0)
            begin
                $error("value: no result expected, got %0d", m_tdata[MOD_W-1:0]);
                fail_count++;
            end
            else
            begin
                want = residue_q.pop_front();
                if (m_tdata[MOD_W-1:0] !== want)
                begin
                    $error("value: expected %0d, got %0d", want, m_tdata[MOD_W-1:0]);
                    fail_count++;
                end
            end
        end
    end

    // Result side: random stalls, and a long hold-off on request.
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                w = HOLD_CYCLES;
            end
            else
                w = quiet ? 0 : $urandom_range(0, 4);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_beat(cmd_t c, logic [31:0] opd);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= opd;
        s_tuser  <= {5'b0, c};
        do @(posedge clk); while (!s_tready);
        residue_q.push_back(apply_command(c, opd));
        sent_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (residue_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic apb_transfer(bit wr, logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_MODULUS;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_modulus_readback();
        logic [DATA_W-1:0] rd;
        apb_transfer(1'b0, '0, rd);
        if (rd !== {1'b0, modulus_shadow})
        begin
            $error("modulus: expected %0d, got %0d", modulus_shadow, rd);
            fail_count++;
        end
    endtask

    task automatic write_modulus(logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] rd;
        apb_transfer(1'b1, val, rd);
        modulus_shadow = val[MOD_W-1:0];
        check_modulus_readback();
    endtask

    function automatic logic [31:0] pick_modulus();
        logic [31:0] primes[6] = '{3, 7, 13, 251, 65521, 2147483629};
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 3);
            1: return primes[$urandom_range(0, 5)];
            2: return $urandom_range(2, 255);
            3: return $urandom_range(2, 65535);
            4: return 32'h7FFF_FFFF;
            5: return 32'(DEFAULT_MODULUS);
            6: return $urandom();
            7: return 32'h8000_0000 | $urandom_range(0, 4095);
            default: return $urandom_range(2, 4095);
        endcase
    endfunction

    function automatic logic [31:0] pick_operand();
        longint unsigned m;
        m = effective_modulus();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom();
            4: return $urandom_range(0, 15);
            5:
            case ($urandom_range(0, 3))
                0: return 32'(m - 1);
                1: return 32'(m);
                2: return 32'(m + 1);
                default: return 32'(2 * m);
            endcase
            6: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return 32'(64'($urandom()) % m);
        endcase
    endfunction

    function automatic cmd_t pick_command();
        int r;
        int div_top;
        r = $urandom_range(0, 99);
        div_top = (effective_modulus() > 65536) ? 65 : 72;
        if (r < 8)
            return CMD_LOAD;
        else if (r < 26)
            return CMD_ADD;
        else if (r < 44)
            return CMD_SUB;
        else if (r < 62)
            return CMD_MUL;
        else if (r < div_top)
            return CMD_DIV;
        else if (r < 82)
            return CMD_INC;
        else if (r < 96)
            return CMD_DEC;
        return CMD_NOP;
    endfunction

    task automatic test_reset_modulus();
        check_modulus_readback();
        send_beat(CMD_LOAD, 32'hFFFF_FFFF);
        send_beat(CMD_ADD,  32'hFFFF_FFFF);
        send_beat(CMD_MUL,  32'h8000_0000);
        send_beat(CMD_LOAD, 32'd5);
        send_beat(CMD_SUB,  32'd7);
        send_beat(CMD_DIV,  32'd0);
        send_beat(CMD_LOAD, 32'd10);
        send_beat(CMD_DIV,  32'(DEFAULT_MODULUS));
        send_beat(CMD_LOAD, 32'd10);
        send_beat(CMD_DIV,  32'd3);
        send_beat(CMD_MUL,  32'd3);
        send_beat(CMD_LOAD, 32'd0);
        send_beat(CMD_DEC,  32'hFFFF_FFFF);
        send_beat(CMD_INC,  32'h0);
        send_beat(CMD_NOP,  32'hDEAD_BEEF);
        drain();
    endtask

    task automatic test_modulus_extremes();
        write_modulus(32'd0);
        send_beat(CMD_LOAD, 32'd3);
        send_beat(CMD_INC,  32'd0);
        send_beat(CMD_DIV,  32'd1);
        send_beat(CMD_DEC,  32'd0);
        drain();
        write_modulus(32'd1);
        send_beat(CMD_ADD,  32'd1);
        drain();
        write_modulus(32'hFFFF_FFFF);
        send_beat(CMD_LOAD, 32'hFFFF_FFFF);
        send_beat(CMD_DIV,  32'd2);
        send_beat(CMD_SUB,  32'h7FFF_FFFE);
        drain();
    endtask

    task automatic test_stale_accumulator();
        write_modulus(32'h7FFF_FFFF);
        send_beat(CMD_LOAD, 32'd2000000000);
        drain();
        write_modulus(32'd13);
        send_beat(CMD_NOP,  32'd0);
        send_beat(CMD_INC,  32'd0);
        drain();
    endtask

    task automatic test_output_backpressure();
        write_modulus(32'd65521);
        quiet = 1'b1;
        hold_request = 1'b1;
        repeat (12) send_beat($urandom_range(0, 1) ? CMD_ADD : CMD_MUL, $urandom());
        drain();
        quiet = 1'b0;
    endtask

    task automatic test_random_phases();
        int n;
        while (sent_count < RANDOM_BEATS)
        begin
            write_modulus(pick_modulus());
            quiet = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 60);
            repeat (n) send_beat(pick_command(), pick_operand());
            drain();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_modulus_extremes();
        test_stale_accumulator();
        test_output_backpressure();
        test_random_phases();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
